/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the comment stripper RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/ccs_pkg.sv */
// ---------------------------------------------------------------------------
// ccs_pkg
// Lexer modes, character codes and the per-byte step of the stripper.
// ---------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [3:0] {
        MODE_CODE      = 4'd0,
        MODE_SLASH     = 4'd1,
        MODE_LINE_CMT  = 4'd2,
        MODE_BLOCK_CMT = 4'd3,
        MODE_BLOCK_STAR = 4'd4,
        MODE_STRING    = 4'd5,
        MODE_CHAR_OPEN = 4'd6,
        MODE_STR_ESC   = 4'd7,
        MODE_CHAR_ESC  = 4'd8,
        MODE_CHAR_REST = 4'd9
    } lexer_mode_t;

    // Outcome of one byte through the mode machine: at most two bytes out.
    typedef struct packed {
        lexer_mode_t mode;
        logic [1:0]  count;
        logic [7:0]  b0;
        logic [7:0]  b1;
    } consume_t;

    // Results of one request, up to three bytes, slot 0 first.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } step_t;

    function automatic consume_t consume_byte(lexer_mode_t mode, logic [7:0] c);
        consume_t r;
        r.mode  = mode;
        r.count = 2'd0;
        r.b0    = c;
        r.b1    = 8'h00;
        case (mode)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    r.mode = MODE_LINE_CMT;
                end
                else if (c == CH_STAR)
                begin
                    r.mode = MODE_BLOCK_CMT;
                end
                else
                begin
                    // release the held slash ahead of this byte
                    r.b0    = CH_SLASH;
                    r.b1    = c;
                    r.count = 2'd2;
                    r.mode  = MODE_CODE;
                end
            end
            MODE_LINE_CMT:
            begin
                if (c == CH_NL)
                begin
                    r.count = 2'd1;
                    r.mode  = MODE_CODE;
                end
            end
            MODE_BLOCK_CMT:
            begin
                if (c == CH_STAR)
                begin
                    r.mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR:
            begin
                if (c == CH_SLASH)
                begin
                    r.mode = MODE_CODE;
                end
                else if (c != CH_STAR)
                begin
                    r.mode = MODE_BLOCK_CMT;
                end
            end
            MODE_STRING:
            begin
                r.count = 2'd1;
                if (c == CH_DQUOTE)
                begin
                    r.mode = MODE_CODE;
                end
                else if (c == CH_BSLASH)
                begin
                    r.mode = MODE_STR_ESC;
                end
            end
            MODE_CHAR_OPEN:
            begin
                r.count = 2'd1;
                r.mode  = (c == CH_BSLASH) ? MODE_CHAR_ESC : MODE_CHAR_REST;
            end
            MODE_STR_ESC:
            begin
                r.count = 2'd1;
                r.mode  = MODE_STRING;
            end
            MODE_CHAR_ESC:
            begin
                r.count = 2'd1;
                r.mode  = MODE_CHAR_REST;
            end
            MODE_CHAR_REST:
            begin
                r.count = 2'd1;
                if (c == CH_SQUOTE)
                begin
                    r.mode = MODE_CODE;
                end
            end
            default:
            begin
                if (c == CH_SLASH)
                begin
                    r.mode = MODE_SLASH;
                end
                else
                begin
                    r.count = 2'd1;
                    if (c == CH_DQUOTE)
                    begin
                        r.mode = MODE_STRING;
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        r.mode = MODE_CHAR_OPEN;
                    end
                    else
                    begin
                        r.mode = MODE_CODE;
                    end
                end
            end
        endcase
        return r;
    endfunction

endpackage

/* sv/ccs_lexer.sv */
// ---------------------------------------------------------------------------
// ccs_lexer
// Input register, lexer mode register and the per-request step logic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccs_lexer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           char_in,
    input  logic                 end_of_text,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  logic                 advance,
    output logic                 held_valid,
    output ccs_pkg::step_t       step
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [7:0]           char_reg;
    logic                 eot_reg;
    ccs_pkg::lexer_mode_t mode_reg;
    ccs_pkg::lexer_mode_t mode_next;
    ccs_pkg::consume_t    first;
    ccs_pkg::consume_t    flush;
    logic                 accept;

    assign text_stall = valid_reg && !advance;
    assign accept     = text_valid && !text_stall;
    assign held_valid = valid_reg;

    always_comb
    begin
        first = ccs_pkg::consume_byte(mode_reg, char_reg);
        flush = ccs_pkg::consume_byte(first.mode, ccs_pkg::CH_NL);
        // supply the missing final newline
        if (!(eot_reg && (char_reg != ccs_pkg::CH_NL)))
        begin
            flush.count = 2'd0;
        end
        step.count = first.count + flush.count;
        case (first.count)
            2'd1:    step.bytes = {flush.b0, flush.b0, first.b0};
            2'd2:    step.bytes = {flush.b0, first.b1, first.b0};
            default: step.bytes = {flush.b1, flush.b1, flush.b0};
        endcase
        // slot 2 only matters when three bytes come out
        if (first.count == 2'd1)
        begin
            step.bytes[1] = flush.b0;
            step.bytes[2] = flush.b1;
        end
        mode_next  = eot_reg ? ccs_pkg::MODE_CODE : first.mode;
        valid_next = accept ? 1'b1 : (advance ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mode_reg  <= ccs_pkg::MODE_CODE;
        end
        else
        begin
            valid_reg <= valid_next;
            if (advance)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_in;
            eot_reg  <= end_of_text;
        end
    end

    `ASSERT_NEXT(a_held_request_stays, clk, rst_n, valid_reg && !advance,
                 valid_reg && $stable(char_reg) && $stable(eot_reg))
    `ASSERT_NEXT(a_eot_returns_to_code, clk, rst_n, advance && eot_reg,
                 mode_reg == ccs_pkg::MODE_CODE)
    `ASSERT_IMPL(a_advance_needs_item, clk, rst_n, advance, valid_reg)

endmodule

/* sv/ccs_out_buf.sv */
// ---------------------------------------------------------------------------
// ccs_out_buf
// Result register holding up to three bytes, drained one byte per cycle while strip_stall is low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccs_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  ccs_pkg::step_t step,
    output logic           free,
    output logic [7:0]     char_out,
    output logic           last_of_run,
    output logic           strip_valid,
    input  logic           strip_stall
);

    logic            valid_reg;
    logic            valid_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;
    logic [2:0][7:0] bytes_reg;
    logic            taken;

    assign strip_valid = valid_reg;
    assign char_out    = bytes_reg[idx_reg];
    assign last_of_run = (idx_reg == (cnt_reg - 2'd1));
    assign taken       = valid_reg && !strip_stall;
    assign free        = !valid_reg || (taken && last_of_run);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (taken)
        begin
            if (last_of_run)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            cnt_reg   <= 2'd1;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            if (load)
            begin
                cnt_reg <= step.count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= step.bytes;
        end
    end

    `ASSERT_IMPL(a_load_when_free, clk, rst_n, load, free && (step.count != 2'd0))
    `ASSERT_IMPL(a_index_in_run, clk, rst_n, valid_reg,
                 (cnt_reg != 2'd0) && (idx_reg < cnt_reg))
    `ASSERT_NEXT(a_stalled_byte_holds, clk, rst_n, valid_reg && strip_stall,
                 valid_reg && $stable(char_out) && $stable(last_of_run))

endmodule

/* sv/c_comment_stripper.sv */
// ---------------------------------------------------------------------------
// c_comment_stripper
// Removes C comments from a byte stream, one source byte per request.
// ---------------------------------------------------------------------------
// The first result byte of a request is offered from the result register, which
//   the input register loads; a request that yields no bytes offers nothing.
// Throughput: one request per cycle while strip_stall is low; the result register
//   drains one byte per cycle and holds a request's bytes until the last is taken.
// Reset: rst_n clears the lexer mode to plain code and empties both stages.
module c_comment_stripper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    input  logic       text_valid,
    output logic       text_stall,
    output logic [7:0] char_out,
    output logic       last_of_run,
    output logic       strip_valid,
    input  logic       strip_stall
);

    ccs_pkg::step_t step;
    logic           held_valid;
    logic           free;
    logic           advance;
    logic           load;

    // a request with no output bytes never needs the result register
    assign advance = held_valid && ((step.count == 2'd0) || free);
    assign load    = advance && (step.count != 2'd0);

    ccs_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .advance     (advance),
        .held_valid  (held_valid),
        .step        (step)
    );

    ccs_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .step        (step),
        .free        (free),
        .char_out    (char_out),
        .last_of_run (last_of_run),
        .strip_valid (strip_valid),
        .strip_stall (strip_stall)
    );

endmodule
